// ===== src/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while rst is high
`define CHK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on clk, also live during reset
`define CHK_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dwmt_pkg.sv =====
// shared constants, types and codes of the window max tracker
package dwmt_pkg;

  // history depth, a power of two so slot arithmetic wraps by truncation
  localparam int DEPTH      = 1024;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int LEN_W      = 11;
  localparam int RATIO_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 56;

  localparam logic [LEN_W-1:0]   WIN_LEN_RESET = LEN_W'(DEPTH);
  localparam logic [RATIO_W-1:0] RATIO_RESET   = RATIO_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH    = 1'b0,
    REG_DECIMATION_RATIO = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_DROP,
    ST_WRITE,
    ST_TRIM,
    ST_DROP,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [IDX_W-1:0] addr;
    sample_t          wdata;
  } mem_req_t;

  typedef struct packed {
    logic             new_sample;
    sample_t          window_max;
    logic [CNT_W-1:0] max_copies;
    logic [CNT_W-1:0] fill_level;
  } result_t;

endpackage

// ===== src/decimated_window_max_tracker_core.sv =====
// top level of the decimated window max tracker
//
// input stream (s_*): one request per tick, s_tdata holds the signed q16.16
// sample. a down-counter decides which ticks push their sample into the
// history window (window_length newest taken samples, at least 1, at most 1024).
// output stream (m_*): exactly one result per tick with the new_sample flag,
// the window maximum, how many window entries equal it and the fill level.
// configuration: cfg_we/cfg_index/cfg_data, index 0 window_length,
// index 1 decimation_ratio; write only while the block is idle.
// sequence: a skipped tick goes idle, trim, done; a taken sample goes idle,
// write, trim, done, with a full-drop read first when the history is full;
// every evicted entry adds a drop state after a trim, and the result then
// passes through the output register. when the last copy of the maximum is
// evicted the history memory is rescanned at one entry a cycle through its
// single port, from the oldest entry over fill_level entries.
// reset: synchronous; clears the window, counters and output valid, and sets
// the maximum to the most negative value. history needs no clearing.
// a stalled receiver: the output register holds the result and the next
// request is still taken; its result waits until the register drains.
module decimated_window_max_tracker_core
  import dwmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,  // [31:0] sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata   // [0] new_sample, [32:1] window_max,
                                          // [43:33] max_copies, [54:44] fill_level
);

  mem_req_t mem_req;
  sample_t  mem_rdata;
  result_t  res;
  logic     res_valid;
  logic     out_free;
  result_t  out_q;

  // output slot is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  dwmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_sample (sample_t'(s_tdata)),
    .in_ready  (s_tready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  dwmt_hist_ram u_hist (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output register between the sequencer and the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  // pack fields lowest first, pad to whole bytes
  assign m_tdata = {1'b0, out_q.fill_level, out_q.max_copies,
                    out_q.window_max, out_q.new_sample};

endmodule

// ===== src/dwmt_hist_ram.sv =====
// single-port history memory with registered read
module dwmt_hist_ram
  import dwmt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output sample_t  rdata
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ===== src/dwmt_ctrl.sv =====
// sequencer: decimation, max tracking, eviction and window rescan
module dwmt_ctrl
  import dwmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  sample_t               in_sample,
  output logic                  in_ready,
  input  logic                  out_free,
  output logic                  res_valid,
  output result_t               res,
  output mem_req_t              mem_req,
  input  sample_t               mem_rdata
);

  state_t             state, state_next;
  logic [IDX_W-1:0]   newest_index;
  logic [CNT_W-1:0]   occupancy;
  logic [RATIO_W-1:0] countdown;
  sample_t            running_max;
  logic [CNT_W-1:0]   top_copies;
  logic [LEN_W-1:0]   window_length;
  logic [RATIO_W-1:0] decimation_ratio;
  sample_t            sample_q;
  logic               took;
  logic               need_rescan;
  logic [IDX_W-1:0]   scan_pos;
  logic [CNT_W-1:0]   scan_left;
  logic               scan_pend;
  sample_t            best;
  logic [CNT_W-1:0]   best_cnt;

  logic [CNT_W-1:0]   limit;
  logic [IDX_W-1:0]   oldest;
  logic               accept;
  logic               take;
  logic               full;
  logic               over;
  logic               hit;
  logic [CNT_W-1:0]   cnt_dec;
  logic               drop_zero;
  logic               scan_done;

  always_comb begin
    if (window_length == '0) begin
      limit = CNT_W'(1);
    end else if (window_length > LEN_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(window_length);
    end
  end

  assign oldest    = newest_index + IDX_W'(1) - occupancy[IDX_W-1:0];
  assign accept    = in_valid && (state == ST_IDLE);
  assign take      = countdown <= RATIO_W'(1);
  assign full      = occupancy == CNT_W'(DEPTH);
  assign over      = occupancy > limit;
  assign hit       = mem_rdata == running_max;
  assign cnt_dec   = (top_copies != '0) ? top_copies - CNT_W'(1) : top_copies;
  assign drop_zero = hit && (cnt_dec == '0);
  assign scan_done = (scan_left == '0) && !scan_pend;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!take) begin
            state_next = ST_TRIM;
          end else if (full) begin
            state_next = ST_FULL_DROP;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_FULL_DROP: state_next = ST_WRITE;
      ST_WRITE:     state_next = need_rescan ? ST_SCAN_INIT : ST_TRIM;
      ST_TRIM:      state_next = over ? ST_DROP : ST_DONE;
      ST_DROP:      state_next = drop_zero ? ST_SCAN_INIT : ST_TRIM;
      ST_SCAN_INIT: state_next = ST_SCAN;
      ST_SCAN:      state_next = scan_done ? ST_TRIM : ST_SCAN;
      ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs and memory requests
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = sample_q;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && take && full) begin
          mem_req.en   = 1'b1;
          mem_req.addr = oldest;
        end
      end
      ST_WRITE: begin
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = newest_index + IDX_W'(1);
      end
      ST_TRIM: begin
        if (over) begin
          mem_req.en   = 1'b1;
          mem_req.addr = oldest;
        end
      end
      ST_SCAN: begin
        if (scan_left != '0) begin
          mem_req.en   = 1'b1;
          mem_req.addr = scan_pos;
        end
      end
      ST_DONE:  res_valid = out_free;
      default: begin
        mem_req.en = 1'b0;
      end
    endcase
  end

  assign res.new_sample = took;
  assign res.window_max = running_max;
  assign res.max_copies = top_copies;
  assign res.fill_level = occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WIN_LEN_RESET;
      decimation_ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data[LEN_W-1:0];
      end else begin
        decimation_ratio <= cfg_data[RATIO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      newest_index <= '0;
      occupancy    <= '0;
      countdown    <= '0;
      running_max  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      top_copies   <= '0;
      need_rescan  <= 1'b0;
      scan_pend    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sample_q    <= in_sample;
            took        <= take;
            need_rescan <= 1'b0;
            if (take) begin
              countdown <= decimation_ratio;
              if ((top_copies == '0) || (in_sample > running_max)) begin
                running_max <= in_sample;
                top_copies  <= CNT_W'(1);
              end else if (in_sample == running_max) begin
                top_copies <= top_copies + CNT_W'(1);
              end
            end else begin
              countdown <= countdown - RATIO_W'(1);
            end
          end
        end
        ST_FULL_DROP: begin
          occupancy <= occupancy - CNT_W'(1);
          if (hit) begin
            top_copies <= cnt_dec;
          end
          need_rescan <= drop_zero;
        end
        ST_WRITE: begin
          newest_index <= newest_index + IDX_W'(1);
          occupancy    <= occupancy + CNT_W'(1);
        end
        ST_DROP: begin
          occupancy <= occupancy - CNT_W'(1);
          if (hit) begin
            top_copies <= cnt_dec;
          end
        end
        ST_SCAN_INIT: begin
          scan_pos  <= oldest;
          scan_left <= occupancy;
          scan_pend <= 1'b0;
          best_cnt  <= '0;
        end
        ST_SCAN: begin
          scan_pend <= scan_left != '0;
          if (scan_left != '0) begin
            scan_pos  <= scan_pos + IDX_W'(1);
            scan_left <= scan_left - CNT_W'(1);
          end
          if (scan_pend) begin
            if ((best_cnt == '0) || (mem_rdata > best)) begin
              best     <= mem_rdata;
              best_cnt <= CNT_W'(1);
            end else if (mem_rdata == best) begin
              best_cnt <= best_cnt + CNT_W'(1);
            end
          end
          if (scan_done) begin
            if (best_cnt != '0) begin
              running_max <= best;
            end
            top_copies <= best_cnt;
          end
        end
        default: begin
          scan_pend <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/dwmt_checker.sv =====
// port-level checker for the window max tracker, bound to the top level
`include "assert_macros.svh"

module dwmt_checker
  import dwmt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] copies;
  logic             took;

  assign took   = m_tdata[0];
  assign copies = m_tdata[43:33];
  assign fill   = m_tdata[54:44];

  `CHK_ASSERT_RST(a_reset_clears_out, rst |=> !m_tvalid, "result valid after reset")
  `CHK_ASSERT(a_fill_bound, m_tvalid |-> (fill <= CNT_W'(DEPTH)), "fill level above depth")
  `CHK_ASSERT(a_copies_bound, m_tvalid |-> (copies <= fill), "max copies above fill level")
  `CHK_ASSERT(a_taken_nonempty, (m_tvalid && took) |-> (fill != '0), "taken sample, empty window")
  `CHK_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result dropped")

endmodule

bind decimated_window_max_tracker_core dwmt_checker u_dwmt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
